/* hdl/gmo_pkg.sv */
// ---------------------------------------------------------------------------
// gmo_pkg - shared types and constants
// Register indexes, filter modes and the item types passed between the
// window cells of the octagon morphology filter.
// ---------------------------------------------------------------------------
package gmo_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int CFG_DW         = 11;
    localparam int RST_SIZE       = 512;

    localparam logic [7:0] PIX_BLACK = 8'h00;
    localparam logic [7:0] PIX_WHITE = 8'hFF;

    typedef enum logic [1:0] {
        MODE_DILATE = 2'd0,
        MODE_ERODE  = 2'd1,
        MODE_OPEN   = 2'd2,
        MODE_CLOSE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } t_reg_idx;

    // per-item flags carried down a cell's pipeline
    typedef struct packed {
        logic       emit;   // a centre position exists for this item
        logic       has;    // the centre lies inside the image
        logic       last;   // final stream position of the frame for this cell
        logic [4:0] rmask;  // row offsets -2..2 inside the image
        logic [4:0] cmask;  // column offsets -2..2 inside the image
    } t_tag;

    typedef struct packed {
        logic       valid;
        logic       has;
        logic       last;
        logic [7:0] pixel;
    } t_item;

    // octagon taps in the window: row i (0 = newest row), column j (0 = newest)
    function automatic logic tap_used(input int i, input int j);
        return (i == 0 && j <= 2) || (i >= 1 && i <= 3) || (i == 4 && j >= 1 && j <= 3);
    endfunction

    // index into the column mask (offset + 2); newest row is shifted by one
    function automatic int tap_cidx(input int i, input int j);
        if (!tap_used(i, j)) return 0;
        return (i == 0) ? 3 - j : 4 - j;
    endfunction

endpackage

/* hdl/gray_morphology_octagon.sv */
// ---------------------------------------------------------------------------
// gray_morphology_octagon - grayscale morphology, flat 21-point octagon
// Dilation, erosion, opening or closing of an 8-bit raster image.
// ---------------------------------------------------------------------------
// Pixels arrive on the input channel in raster order, i_kind low. After the
// last pixel the host sends drain items (i_kind high): 2*W+1 of them for
// dilation or erosion, twice that for opening or closing. Each item that
// completes a window gives one filtered pixel on the output channel, and
// o_end_of_frame marks the last pixel of the image; the next pixel then
// starts a new frame. A drain sent before the image is complete is dropped.
// Throughput is one item per clock while the output queue has room. An item
// passes four pipeline stages per cell, in one cell or in two by mode, then
// the output queue. Configuration writes take effect at once and restart
// the frame; the user must issue them only while the block is idle, and the
// block itself does not enforce this. Reset returns mode to dilation, the
// size to 512x512 and empties the pipeline. The line stores are not
// cleared. When the receiver stalls, a two-entry output queue fills and
// then o_in_ready falls, freezing the whole pipeline until a result leaves.
// ---------------------------------------------------------------------------
module gray_morphology_octagon #(
    parameter int MAX_WIDTH  = gmo_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gmo_pkg::DEF_MAX_HEIGHT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_kind,
    input  logic [7:0]                i_pixel_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [7:0]                o_pixel_out,
    output logic                      o_end_of_frame,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [gmo_pkg::CFG_DW-1:0] i_cfg_data
);
    import gmo_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 6);
    localparam int RST_W = (RST_SIZE > MAX_WIDTH)  ? MAX_WIDTH  : RST_SIZE;
    localparam int RST_H = (RST_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : RST_SIZE;

    t_mode         r_mode;
    logic [WW-1:0] r_width;
    logic [RW-1:0] r_height;
    logic [WW-1:0] cfg_w;
    logic [RW-1:0] cfg_h;
    logic          restart;

    logic          two, max1, max2, adv;
    logic [RW-1:0] end1_row, end2_row;
    logic [CW-1:0] end1_col;
    logic          need1, need2;
    logic          c1_valid, c2_valid;
    t_item         c1_out, c2_out, fin;

    logic [1:0]    r_cnt;
    logic [7:0]    r_fpix [2];
    logic          r_feof [2];
    logic          push, pop, wpos;

    // clamp sizes to [1, max]
    assign cfg_w = (i_cfg_data == '0) ? WW'(1) :
                   (32'(i_cfg_data) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(i_cfg_data);
    assign cfg_h = (i_cfg_data == '0) ? RW'(1) :
                   (32'(i_cfg_data) > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(i_cfg_data);

    always_comb begin
        restart = 1'b0;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_MODE, REG_WIDTH, REG_HEIGHT: restart = 1'b1;
                default:                         restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_DILATE;
            r_width  <= WW'(RST_W);
            r_height <= RW'(RST_H);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_MODE:   r_mode   <= t_mode'(i_cfg_data[1:0]);
                REG_WIDTH:  r_width  <= cfg_w;
                REG_HEIGHT: r_height <= cfg_h;
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    assign two  = (r_mode == MODE_OPEN) || (r_mode == MODE_CLOSE);
    assign max1 = (r_mode == MODE_DILATE) || (r_mode == MODE_CLOSE);
    assign max2 = (r_mode == MODE_OPEN);

    // last stream position: (H+2)*W for one stage, (H+4)*W+1 for the first of two
    assign end2_row = r_height + RW'(2);
    always_comb begin
        if (!two) begin
            end1_row = end2_row;
            end1_col = '0;
        end else if (r_width == WW'(1)) begin
            end1_row = r_height + RW'(5);
            end1_col = '0;
        end else begin
            end1_row = r_height + RW'(4);
            end1_col = CW'(1);
        end
    end

    assign adv        = (r_cnt != 2'd2);
    assign o_in_ready = adv;
    assign c1_valid   = i_in_valid && (!i_kind || !need1);
    assign c2_valid   = two && c1_out.valid;

    gmo_cell #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_cell1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_restart  (restart),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_end_row  (end1_row),
        .i_end_col  (end1_col),
        .i_take_max (max1),
        .i_valid    (c1_valid),
        .i_pixel    (i_pixel_in),
        .o_item     (c1_out),
        .o_need     (need1)
    );

    gmo_cell #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_cell2 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_restart  (restart),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_end_row  (end2_row),
        .i_end_col  ('0),
        .i_take_max (max2),
        .i_valid    (c2_valid),
        .i_pixel    (c1_out.pixel),
        .o_item     (c2_out),
        .o_need     (need2)
    );

    // output queue, two entries
    assign fin  = two ? c2_out : c1_out;
    assign push = adv && fin.valid && fin.has;
    assign pop  = (r_cnt != 2'd0) && i_out_ready;
    assign wpos = (r_cnt == 2'd1) && !pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    // a full queue takes no new item, so the shift and the write never meet
    always_ff @(posedge i_clk) begin
        if (pop && r_cnt == 2'd2) begin
            r_fpix[0] <= r_fpix[1];
            r_feof[0] <= r_feof[1];
        end
        if (push) begin
            r_fpix[wpos] <= fin.pixel;
            r_feof[wpos] <= fin.last;
        end
    end

    assign o_out_valid    = (r_cnt != 2'd0);
    assign o_pixel_out    = r_fpix[0];
    assign o_end_of_frame = r_feof[0] && !need2 || r_feof[0];

endmodule

/* hdl/gmo_cell.sv */
// ---------------------------------------------------------------------------
// gmo_cell - one morphology stage
// Line store of four rows packed per column, 5x5 window of shifting
// registers, and a two-level max/min reduction over the octagon taps.
// ---------------------------------------------------------------------------
module gmo_cell #(
    parameter int  MAX_WIDTH  = 1024,
    parameter int  MAX_HEIGHT = 1024,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int RW = $clog2(MAX_HEIGHT + 6)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_restart,
    input  logic [WW-1:0]     i_width,
    input  logic [RW-1:0]     i_height,
    input  logic [RW-1:0]     i_end_row,
    input  logic [CW-1:0]     i_end_col,
    input  logic              i_take_max,
    input  logic              i_valid,
    input  logic [7:0]        i_pixel,
    output gmo_pkg::t_item    o_item,
    output logic              o_need
);
    import gmo_pkg::*;

    logic [CW-1:0] r_col,  n_col;
    logic [RW-1:0] r_row,  n_row;
    logic [CW-1:0] r_qcol, n_qcol;
    logic [RW-1:0] r_qrow, n_qrow;

    logic [31:0]   r_mem [MAX_WIDTH];
    logic [31:0]   r_rd, r_byp;
    logic [7:0]    r_xpix;
    t_tag          r_xtag, r_wtag, r_atag, r_btag;
    logic [7:0]    r_win [5][5];
    logic [7:0]    r_arow [5];
    logic [7:0]    n_arow [5];
    logic [7:0]    r_bval, n_bval;
    logic          r_xv, r_wv, r_av, r_bv;

    logic          take;
    logic          col_last, qcol_last, on, wr, last;
    logic [CW-1:0] rd_addr;
    logic [31:0]   eff, new_word;
    logic [7:0]    idn;
    t_tag          tag;

    function automatic logic [7:0] pick(input logic [7:0] a, input logic [7:0] b,
                                        input logic mx);
        if (mx) return (a > b) ? a : b;
        return (a < b) ? a : b;
    endfunction

    assign take      = i_adv && i_valid;
    assign col_last  = (WW'(r_col) == i_width - WW'(1));
    assign qcol_last = (WW'(r_qcol) == i_width - WW'(1));
    assign rd_addr   = col_last ? '0 : r_col + CW'(1);
    // centre exists once the stream is 2*W+1 positions in
    assign on        = (r_row > RW'(2)) || (r_row == RW'(2) && r_col != '0);
    assign wr        = (r_row < i_height);
    assign last      = (r_row == i_end_row) && (r_col == i_end_col);
    // single-column image: read and write hit the same word
    assign eff       = (i_width == WW'(1)) ? r_byp : r_rd;
    assign new_word  = {eff[23:0], i_pixel};
    assign idn       = i_take_max ? PIX_BLACK : PIX_WHITE;
    assign o_need    = wr;

    always_comb begin
        tag.emit     = on;
        tag.has      = on && (r_qrow < i_height);
        tag.last     = last;
        tag.rmask[0] = (r_qrow >= RW'(2));
        tag.rmask[1] = (r_qrow >= RW'(1));
        tag.rmask[2] = (r_qrow < i_height);
        tag.rmask[3] = ({1'b0, r_qrow} + (RW+1)'(1)) < {1'b0, i_height};
        tag.rmask[4] = ({1'b0, r_qrow} + (RW+1)'(2)) < {1'b0, i_height};
        tag.cmask[0] = (r_qcol >= CW'(2));
        tag.cmask[1] = (r_qcol >= CW'(1));
        tag.cmask[2] = 1'b1;
        tag.cmask[3] = ({1'b0, WW'(r_qcol)} + (WW+1)'(1)) < {1'b0, i_width};
        tag.cmask[4] = ({1'b0, WW'(r_qcol)} + (WW+1)'(2)) < {1'b0, i_width};
    end

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_qcol = r_qcol;
        n_qrow = r_qrow;
        if (i_restart) begin
            n_col  = '0;
            n_row  = '0;
            n_qcol = '0;
            n_qrow = '0;
        end else if (take) begin
            if (last) begin
                n_col  = '0;
                n_row  = '0;
                n_qcol = '0;
                n_qrow = '0;
            end else begin
                n_col = col_last ? '0 : r_col + CW'(1);
                n_row = r_row + RW'(col_last);
                if (on) begin
                    n_qcol = qcol_last ? '0 : r_qcol + CW'(1);
                    n_qrow = r_qrow + RW'(qcol_last);
                end
            end
        end
    end

    // per-row reduction with out-of-image taps replaced by the identity
    always_comb begin
        logic [7:0] acc;
        logic       en;
        for (int i = 0; i < 5; i++) begin
            acc = idn;
            for (int j = 0; j < 5; j++) begin
                en = tap_used(i, j) && r_wtag.rmask[3'(4 - i)]
                     && r_wtag.cmask[3'(tap_cidx(i, j))];
                if (en) acc = pick(r_win[i][j], acc, i_take_max);
            end
            n_arow[i] = acc;
        end
    end

    always_comb begin
        n_bval = r_arow[0];
        for (int i = 1; i < 5; i++) n_bval = pick(r_arow[i], n_bval, i_take_max);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_qcol <= '0;
            r_qrow <= '0;
            r_xv   <= 1'b0;
            r_wv   <= 1'b0;
            r_av   <= 1'b0;
            r_bv   <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_qcol <= n_qcol;
            r_qrow <= n_qrow;
            if (i_adv) begin
                r_xv <= i_valid;
                r_wv <= r_xv;
                r_av <= r_wv;
                r_bv <= r_av;
            end
        end
    end

    // rows below the image are still shifted in so the older rows stay aligned
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mem[r_col] <= new_word;
            r_rd   <= r_mem[rd_addr];
            r_byp  <= new_word;
            r_xpix <= i_pixel;
            r_xtag <= tag;
        end
        if (i_adv && r_xv) begin
            for (int i = 0; i < 5; i++) begin
                for (int j = 4; j > 0; j--) r_win[i][j] <= r_win[i][j-1];
            end
            r_win[0][0] <= r_xpix;
            for (int i = 1; i < 5; i++) r_win[i][0] <= eff[8*(i-1) +: 8];
            r_wtag <= r_xtag;
        end
        if (i_adv && r_wv) begin
            for (int i = 0; i < 5; i++) r_arow[i] <= n_arow[i];
            r_atag <= r_wtag;
        end
        if (i_adv && r_av) begin
            r_bval <= n_bval;
            r_btag <= r_atag;
        end
    end

    always_comb begin
        o_item.valid = r_bv && r_btag.emit;
        o_item.has   = r_btag.has;
        o_item.last  = r_btag.last;
        o_item.pixel = r_bval;
    end

endmodule

/* hdl/gmo_checker.sv */
// ---------------------------------------------------------------------------
// gmo_checker - port-level checks
// Output hold under stall, reset behaviour and input back-pressure.
// ---------------------------------------------------------------------------
module gmo_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       i_kind,
    input logic [7:0]                 i_pixel_in,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [7:0]                 o_pixel_out,
    input logic                       o_end_of_frame,
    input logic                       i_cfg_we,
    input logic [1:0]                 i_cfg_index,
    input logic [gmo_pkg::CFG_DW-1:0] i_cfg_data
);
    import gmo_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_pixel_out) && $stable(o_end_of_frame))
        else $error("stalled output item changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

    // back-pressure only while the queue is full of waiting items
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no waiting result");

    a_stall_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> $past(o_out_valid))
        else $error("queue filled in a single cycle");

endmodule

bind gray_morphology_octagon gmo_checker u_gmo_checker (.*);

/* bench/gray_morphology_octagon_tb.sv */
// ---------------------------------------------------------------------------
// gray_morphology_octagon_tb - self-checking bench for the octagon filter
// Streams small raster images through every mode and size extreme, with
// random idling on both channels and a long output stall. A behavioural
// model of the two morphology stages predicts every filtered pixel, and a
// checker compares each output item with the oldest prediction.
// ---------------------------------------------------------------------------
module gray_morphology_octagon_tb;
    import gmo_pkg::*;

    localparam int MAXW      = 1024;
    localparam int MAXH      = 1024;
    localparam int HIST      = 4 * MAXW + 4;
    localparam int SETTLE    = 20;
    localparam int HOLD_LEN  = 300;

    typedef struct {
        logic [7:0] pixel;
        logic       eof;
    } t_filtered;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_kind;
    logic [7:0]  i_pixel_in;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_pixel_out;
    logic        o_end_of_frame;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [CFG_DW-1:0] i_cfg_data;

    gray_morphology_octagon i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_pixel_in    (i_pixel_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_out   (o_pixel_out),
        .o_end_of_frame(o_end_of_frame),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor state
    logic [7:0] stage1_hist [HIST];
    logic [7:0] stage2_hist [HIST];
    t_mode      cur_mode;
    int         img_w;
    int         img_h;
    int         stream_pos;
    t_filtered  pending_pixels[$];

    int  errors;
    int  taken_items;   // items that were not dropped as early drains
    bit  no_idle;
    bit  hold_req;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("[gray_morphology_octagon] ERROR");
        $finish;
    end

    task automatic report(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic int clamp_size(input logic [CFG_DW-1:0] v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic logic [7:0] octagon_reduce(input bit second, input int q,
                                                  input bit take_max);
        int r, c, nr, nc;
        logic [7:0] acc, v;
        r   = q / img_w;
        c   = q % img_w;
        acc = take_max ? PIX_BLACK : PIX_WHITE;
        for (int dr = -2; dr <= 2; dr++) begin
            for (int dc = -2; dc <= 2; dc++) begin
                nr = r + dr;
                nc = c + dc;
                if ((dr == -2 || dr == 2) && (dc == -2 || dc == 2)) continue;
                if (nr < 0 || nr >= img_h || nc < 0 || nc >= img_w) continue;
                v = second ? stage2_hist[(nr * img_w + nc) % HIST]
                           : stage1_hist[(nr * img_w + nc) % HIST];
                if (take_max ? (v > acc) : (v < acc)) acc = v;
            end
        end
        return acc;
    endfunction

    task automatic octagon_predict(input logic kind, input logic [7:0] pix);
        int total, delay, t, q;
        bit two, first_max;
        logic [7:0] v;
        total     = img_w * img_h;
        delay     = 2 * img_w + 1;
        two       = (cur_mode == MODE_OPEN || cur_mode == MODE_CLOSE);
        first_max = (cur_mode == MODE_DILATE || cur_mode == MODE_CLOSE);
        t         = stream_pos;
        if (t < total) begin
            if (kind) return;   // early drain is dropped
            stage1_hist[t % HIST] = pix;
        end
        taken_items++;
        stream_pos = t + 1;
        if (t >= delay && t - delay < total) begin
            q = t - delay;
            v = octagon_reduce(1'b0, q, first_max);
            if (!two) begin
                pending_pixels.push_back('{v, q == total - 1});
                if (q == total - 1) stream_pos = 0;
                return;
            end
            stage2_hist[q % HIST] = v;
        end
        if (two && t >= 2 * delay && t - 2 * delay < total) begin
            q = t - 2 * delay;
            v = octagon_reduce(1'b1, q, cur_mode == MODE_OPEN);
            pending_pixels.push_back('{v, q == total - 1});
            if (q == total - 1) stream_pos = 0;
        end
    endtask

    // sender: called at a rising edge, returns at the accepting edge
    task automatic send_item(input logic kind, input logic [7:0] pix);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_pixel_in <= pix;
        do @(negedge i_clk); while (o_in_ready !== 1'b1);
        @(posedge i_clk);
        octagon_predict(kind, pix);
    endtask

    task automatic wait_idle();
        if (i_in_valid) i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // writes all three registers back to back; block must be idle
    task automatic configure(input t_mode m, input logic [CFG_DW-1:0] w,
                             input logic [CFG_DW-1:0] h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_MODE;
        i_cfg_data  <= CFG_DW'(m);
        @(posedge i_clk);
        i_cfg_index <= REG_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        i_cfg_index <= REG_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_mode   = m;
        img_w      = clamp_size(w, MAXW);
        img_h      = clamp_size(h, MAXH);
        stream_pos = 0;
    endtask

    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(0, 5))
            0:       return PIX_BLACK;
            1:       return PIX_WHITE;
            2:       return 8'($urandom_range(100, 140));
            default: return 8'($urandom);
        endcase
    endfunction

    // one full image plus its drain; noise adds early drains and late pixels
    task automatic run_frame(input bit noise);
        int n_drain;
        n_drain = (2 * img_w + 1) * ((cur_mode == MODE_OPEN || cur_mode == MODE_CLOSE) ? 2 : 1);
        for (int i = 0; i < img_w * img_h; i++) begin
            if (noise && $urandom_range(0, 9) == 0) send_item(1'b1, 8'($urandom));
            send_item(1'b0, pick_pixel());
        end
        for (int i = 0; i < n_drain; i++)
            send_item((noise && $urandom_range(0, 3) == 0) ? 1'b0 : 1'b1, 8'($urandom));
    endtask

    // receiver and checker
    initial begin
        t_filtered want;
        logic [7:0] got_pix;
        logic       got_eof;
        int gap;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_req = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(negedge i_clk); while (o_out_valid !== 1'b1);
            got_pix = o_pixel_out;
            got_eof = o_end_of_frame;
            @(posedge i_clk);
            if (pending_pixels.size() == 0) begin
                report($sformatf("unexpected pixel %0d eof %0b", got_pix, got_eof));
            end else begin
                want = pending_pixels.pop_front();
                if (got_pix !== want.pixel)
                    report($sformatf("pixel_out %0d, want %0d", got_pix, want.pixel));
                if (got_eof !== want.eof)
                    report($sformatf("end_of_frame %0b, want %0b", got_eof, want.eof));
            end
        end
    end

    task automatic test_small_images();
        // every mode on tiny images, extremes of pixel values
        configure(MODE_DILATE, 1, 1);
        send_item(1'b0, PIX_WHITE);
        repeat (3) send_item(1'b1, 8'h00);
        wait_idle();
        configure(MODE_ERODE, 2, 2);
        send_item(1'b0, PIX_BLACK);
        send_item(1'b0, PIX_WHITE);
        send_item(1'b0, 8'h55);
        send_item(1'b0, 8'hAA);
        repeat (5) send_item(1'b1, 8'hFF);
        wait_idle();
        configure(MODE_OPEN, 3, 1);
        run_frame(1'b0);
        wait_idle();
        configure(MODE_CLOSE, 1, 3);
        run_frame(1'b0);
        wait_idle();
    endtask

    task automatic test_special_cases();
        // early drains dropped, late pixels taken as drains, clamped sizes
        configure(MODE_CLOSE, 0, 0);
        send_item(1'b1, 8'h12);
        send_item(1'b0, 8'h80);
        send_item(1'b0, 8'h7F);
        repeat (5) send_item(1'b1, 8'h00);
        wait_idle();
        configure(MODE_OPEN, 4, 4);
        run_frame(1'b1);
        wait_idle();
        // partial image then a restart by register write
        configure(MODE_ERODE, 5, 5);
        repeat (4) send_item(1'b0, pick_pixel());
        wait_idle();
        configure(MODE_DILATE, 5, 3);
        run_frame(1'b1);
        wait_idle();
    endtask

    // start of an image at the largest sizes, cut short by a register write
    task automatic test_size_extremes();
        no_idle = 1'b1;
        configure(MODE_ERODE, 2047, 1);
        repeat (24) send_item(1'b0, pick_pixel());
        wait_idle();
        // single tall column: results appear after a few pixels
        configure(MODE_CLOSE, 1, 2047);
        repeat (24) send_item(1'b0, pick_pixel());
        wait_idle();
        configure(MODE_OPEN, 1024, 2);
        repeat (24) send_item(1'b0, pick_pixel());
        wait_idle();
        configure(MODE_DILATE, 1, 1024);
        repeat (24) send_item(1'b0, pick_pixel());
        wait_idle();
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        configure(MODE_OPEN, 6, 6);
        no_idle  = 1'b1;
        hold_req = 1'b1;
        run_frame(1'b0);
        no_idle  = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_frames();
        int start;
        start = taken_items;
        while (taken_items - start < 400) begin
            no_idle = ($urandom_range(0, 4) == 0);
            configure(t_mode'($urandom_range(0, 3)),
                      CFG_DW'($urandom_range(1, 9)), CFG_DW'($urandom_range(1, 7)));
            run_frame($urandom_range(0, 3) == 0);
            wait_idle();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        errors      = 0;
        taken_items = 0;
        no_idle     = 1'b0;
        hold_req    = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_kind      = 1'b0;
        i_pixel_in  = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_MODE;
        i_cfg_data  = '0;
        cur_mode    = MODE_DILATE;
        img_w       = RST_SIZE;
        img_h       = RST_SIZE;
        stream_pos  = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_small_images();
        test_special_cases();
        test_backpressure();
        test_size_extremes();
        test_random_frames();

        wait_idle();
        if (errors == 0) begin
            $display("[gray_morphology_octagon] OK");
        end else begin
            $display("[gray_morphology_octagon] ERROR");
        end
        $finish;
    end

endmodule
